/* rtl/dgb_pkg.sv */
// Shared types, sizes and constants of the density grid binner.
// Used by every module of the block but dgb_ram; depends on nothing.
`timescale 1ns / 1ps
package dgb_pkg;

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 16;
    localparam int COUNT_BITS = 16;

    localparam int BINS_X    = GRID_COLS * 2;
    localparam int BINS_Y    = GRID_ROWS * 4;
    localparam int BIN_TOTAL = BINS_X * BINS_Y;
    localparam int ADDR_W    = $clog2(BIN_TOTAL);
    localparam int BXI_W     = (BINS_X > 1) ? $clog2(BINS_X) : 1;
    localparam int BYI_W     = $clog2(BINS_Y);
    localparam int BX_W      = $clog2(BINS_X + 1);
    localparam int BY_W      = $clog2(BINS_Y + 1);
    localparam int CE_W      = $clog2(GRID_COLS + 1);
    localparam int RE_W      = $clog2(GRID_ROWS + 1);

    localparam int COORD_W = 16;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 4;
    localparam int DEN_W   = 19;
    localparam int MUL_W   = ((BX_W > BY_W) ? BX_W : BY_W) + 1;
    localparam int NUM_W   = DEN_W + MUL_W;
    localparam int SUM_W   = COUNT_BITS + 3;

    localparam logic [SUM_W-1:0] THR_MAGENTA = SUM_W'(10000);
    localparam logic [SUM_W-1:0] THR_RED     = SUM_W'(3010);
    localparam logic [SUM_W-1:0] THR_YELLOW  = SUM_W'(1000);
    localparam logic [SUM_W-1:0] THR_GREEN   = SUM_W'(301);
    localparam logic [SUM_W-1:0] THR_CYAN    = SUM_W'(100);
    localparam logic [SUM_W-1:0] THR_WHITE   = SUM_W'(30);

    localparam logic [2:0] CLS_NONE    = 3'd0;
    localparam logic [2:0] CLS_WHITE   = 3'd1;
    localparam logic [2:0] CLS_CYAN    = 3'd2;
    localparam logic [2:0] CLS_GREEN   = 3'd3;
    localparam logic [2:0] CLS_YELLOW  = 3'd4;
    localparam logic [2:0] CLS_RED     = 3'd5;
    localparam logic [2:0] CLS_MAGENTA = 3'd6;

    localparam int REG_W = 3;
    localparam logic [REG_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [REG_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [REG_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [REG_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [REG_W-1:0] REG_COLS   = 3'd4;
    localparam logic [REG_W-1:0] REG_ROWS   = 3'd5;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_CELL,
        ST_CELL_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CE_W-1:0] cols_eff;
        logic [RE_W-1:0] rows_eff;
        logic [BX_W-1:0] bins_x;
        logic [BY_W-1:0] bins_y;
    } t_grid;

    typedef struct packed {
        t_op              op;
        logic             span_ok;
        logic             cell_ok;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den_x;
        logic [DEN_W-1:0] den_y;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic       counted;
        logic [2:0] cls;
        logic [7:0] dots;
    } t_res;

endpackage

/* rtl/density_grid_binner_braille_cells_unit.sv */
// Top level of the density grid binner: stream ports, register file, front/back.
// Depends on dgb_pkg, dgb_front, dgb_queue and dgb_back.
`timescale 1ns / 1ps
// The block keeps a grid of saturating bin counters (two bins across and four
// down per character cell) and returns exactly one result beat for every input
// beat. tuser carries the operation: add point bins the point with exact signed
// divides and reports whether it counted; read cell returns the braille dot
// pattern and colour class of one cell; clear zeroes the whole grid. Items
// work one at a time in the back end: add point runs the bit-serial dividers;
// read cell makes eight reads through the single read port of the bin RAM;
// clear writes one RAM word a cycle over all BIN_TOTAL bins. After reset a
// clearing pass over all bins runs during which s_axis_tready is low;
// register writes are taken throughout. The front end and a two-entry queue
// keep accepting beats, until both are full, while the back end works and
// while a result beat waits on the master side. Write registers only while
// the block is idle.
module density_grid_binner_braille_cells_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // point_x[15:0], point_y[31:16],
                                         // cell_col[37:32], cell_row[41:38]
    input  logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // dot_pattern[7:0], color_class[10:8],
                                         // point_counted[11]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dgb_pkg::*;

    logic signed [COORD_W-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic [6:0]                r_cols;
    logic [4:0]                r_rows;
    logic [REG_W-1:0]          w_reg;
    logic                      w_wr;
    t_grid                     w_grid;

    logic  w_f_ready, w_f_valid, w_q_ready, w_q_valid, w_pop, w_init, w_b_valid;
    t_cmd  w_f_cmd, w_q_cmd;
    t_res  w_res;

    // register file
    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= 16'sd0;
            r_x_high <= 16'sd255;
            r_y_low  <= 16'sd0;
            r_y_high <= 16'sd255;
            r_cols   <= 7'd64;
            r_rows   <= 5'd16;
        end else if (w_wr) begin
            case (w_reg)
                REG_X_LOW:  r_x_low  <= pwdata[15:0];
                REG_X_HIGH: r_x_high <= pwdata[15:0];
                REG_Y_LOW:  r_y_low  <= pwdata[15:0];
                REG_Y_HIGH: r_y_high <= pwdata[15:0];
                REG_COLS:   r_cols   <= pwdata[6:0];
                REG_ROWS:   r_rows   <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_X_LOW:  prdata = 32'($unsigned(r_x_low));
            REG_X_HIGH: prdata = 32'($unsigned(r_x_high));
            REG_Y_LOW:  prdata = 32'($unsigned(r_y_low));
            REG_Y_HIGH: prdata = 32'($unsigned(r_y_high));
            REG_COLS:   prdata = 32'(r_cols);
            REG_ROWS:   prdata = 32'(r_rows);
            default:    prdata = '0;
        endcase
    end

    // clamp the grid in use to 1..GRID_COLS by 1..GRID_ROWS cells
    always_comb begin
        if (r_cols == '0) begin
            w_grid.cols_eff = CE_W'(1);
        end else if (32'(r_cols) > GRID_COLS) begin
            w_grid.cols_eff = CE_W'(GRID_COLS);
        end else begin
            w_grid.cols_eff = CE_W'(r_cols);
        end
        if (r_rows == '0) begin
            w_grid.rows_eff = RE_W'(1);
        end else if (32'(r_rows) > GRID_ROWS) begin
            w_grid.rows_eff = RE_W'(GRID_ROWS);
        end else begin
            w_grid.rows_eff = RE_W'(r_rows);
        end
        w_grid.bins_x = BX_W'(w_grid.cols_eff) * BX_W'(2);
        w_grid.bins_y = BY_W'(w_grid.rows_eff) * BY_W'(4);
    end

    // hold off input beats during the reset clearing pass
    assign o_s_axis_tready = w_f_ready && !w_init;

    dgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid && !w_init),
        .o_ready (w_f_ready),
        .i_op    (t_op'(i_s_axis_tuser)),
        .i_x     ($signed(i_s_axis_tdata[15:0])),
        .i_y     ($signed(i_s_axis_tdata[31:16])),
        .i_col   (i_s_axis_tdata[37:32]),
        .i_row   (i_s_axis_tdata[41:38]),
        .i_x_low (r_x_low),
        .i_x_high(r_x_high),
        .i_y_low (r_y_low),
        .i_y_high(r_y_high),
        .i_grid  (w_grid),
        .o_valid (w_f_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_f_cmd)
    );

    dgb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_f_valid),
        .o_ready(w_q_ready),
        .i_cmd  (w_f_cmd),
        .o_valid(w_q_valid),
        .i_pop  (w_pop),
        .o_cmd  (w_q_cmd)
    );

    dgb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .o_q_pop  (w_pop),
        .i_q_cmd  (w_q_cmd),
        .i_grid   (w_grid),
        .o_init   (w_init),
        .o_valid  (w_b_valid),
        .i_ready  (i_m_axis_tready),
        .o_res    (w_res)
    );

    assign o_m_axis_tvalid = w_b_valid;
    assign o_m_axis_tdata  = {4'd0, w_res.counted, w_res.cls, w_res.dots};
endmodule

/* rtl/dgb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/dgb_div.sv */
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on dgb_pkg.
`timescale 1ns / 1ps
module dgb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [dgb_pkg::NUM_W-1:0] i_num,
    input  logic signed [dgb_pkg::DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic signed [dgb_pkg::NUM_W-1:0] o_quot
);
    import dgb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, r_done, r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem, r_d;
    logic [DEN_W:0]   w_trial;
    logic             w_fit;

    always_comb begin
        w_trial = {r_rem, r_q[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_q    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                r_d    <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
                r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_d}) : DEN_W'(w_trial);
                r_q   <= {r_q[NUM_W-2:0], w_fit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

/* rtl/dgb_front.sv */
// Front end: takes items, classifies them and forms the divide operands.
// Depends on dgb_pkg.
`timescale 1ns / 1ps
module dgb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  dgb_pkg::t_op                      i_op,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_x,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_y,
    input  logic [dgb_pkg::COL_W-1:0]          i_col,
    input  logic [dgb_pkg::ROW_W-1:0]          i_row,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_x_low,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_x_high,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_y_low,
    input  logic signed [dgb_pkg::COORD_W-1:0] i_y_high,
    input  dgb_pkg::t_grid                    i_grid,
    output logic                              o_valid,
    input  logic                              i_ready,
    output dgb_pkg::t_cmd                     o_cmd
);
    import dgb_pkg::*;

    logic signed [DEN_W-1:0] w_hx, w_hy, w_dx, w_dy, w_xoff, w_yoff;
    logic signed [NUM_W-1:0] w_num_x, w_num_y;
    logic [BX_W-1:0]         w_bxm1;
    logic [BY_W-1:0]         w_bym1;
    t_cmd                    n_cmd;
    logic                    r_valid;
    t_cmd                    r_cmd;
    logic                    w_take;

    always_comb begin
        // equal bounds widen the high end to (high+1)*2
        w_hx   = (i_x_high == i_x_low) ? (DEN_W'(i_x_high) + DEN_W'(1)) * DEN_W'(2)
                                       : DEN_W'(i_x_high);
        w_hy   = (i_y_high == i_y_low) ? (DEN_W'(i_y_high) + DEN_W'(1)) * DEN_W'(2)
                                       : DEN_W'(i_y_high);
        w_dx   = w_hx - DEN_W'(i_x_low);
        w_dy   = w_hy - DEN_W'(i_y_low);
        w_xoff = DEN_W'(i_x) - DEN_W'(i_x_low);
        w_yoff = DEN_W'(i_y) - DEN_W'(i_y_low);
        w_bxm1 = i_grid.bins_x - BX_W'(1);
        w_bym1 = i_grid.bins_y - BY_W'(1);
        w_num_x = NUM_W'(w_xoff) * NUM_W'($signed({1'b0, w_bxm1}));
        w_num_y = NUM_W'(w_dy - w_yoff) * NUM_W'($signed({1'b0, w_bym1}));

        n_cmd         = '0;
        n_cmd.op      = i_op;
        n_cmd.span_ok = (w_dx != '0) && (w_dy != '0);
        n_cmd.cell_ok = (32'(i_col) < 32'(i_grid.cols_eff)) &&
                        (32'(i_row) < 32'(i_grid.rows_eff));
        n_cmd.num_x   = w_num_x;
        n_cmd.num_y   = w_num_y;
        n_cmd.den_x   = w_dx;
        n_cmd.den_y   = w_dy;
        n_cmd.col     = i_col;
        n_cmd.row     = i_row;
    end

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;
endmodule

/* rtl/dgb_queue.sv */
// Short command queue between front and back end.
// Depends on dgb_pkg.
`timescale 1ns / 1ps
module dgb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  dgb_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output dgb_pkg::t_cmd  o_cmd
);
    import dgb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push, w_pop;

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (32'(r_wr) == Q_DEPTH - 1) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (32'(r_rd) == Q_DEPTH - 1) ? '0 : r_rd + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(w_push) - Q_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

/* rtl/dgb_back.sv */
// Back end: bin memory, dividers, cell readout and the result register.
// Depends on dgb_pkg, dgb_div and dgb_ram.
`timescale 1ns / 1ps
module dgb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  dgb_pkg::t_cmd  i_q_cmd,
    input  dgb_pkg::t_grid i_grid,
    output logic           o_init,
    output logic           o_valid,
    input  logic           i_ready,
    output dgb_pkg::t_res  o_res
);
    import dgb_pkg::*;

    t_state                   r_state, n_state;
    t_cmd                     r_cmd;
    logic [ADDR_W-1:0]        r_addr;
    logic [3:0]               r_idx;
    logic [SUM_W-1:0]         r_sum;
    logic [7:0]               r_pat;
    logic                     r_all, r_reply;
    t_res                     r_res, r_out;
    logic                     r_out_valid;

    logic                     w_div_start, w_done_x, w_done_y, w_out_free, w_in_range;
    logic signed [NUM_W-1:0]  w_qx, w_qy;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_raddr, w_bin_addr, w_cell_addr;
    logic [COUNT_BITS-1:0]    w_wdata, w_rdata;
    logic [2:0]               w_bit, w_cls;
    logic                     w_sweep_end;

    dgb_div u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  ($signed(i_q_cmd.num_x)),
        .i_den  ($signed(i_q_cmd.den_x)),
        .o_done (w_done_x),
        .o_quot (w_qx)
    );

    dgb_div u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  ($signed(i_q_cmd.num_y)),
        .i_den  ($signed(i_q_cmd.den_y)),
        .o_done (w_done_y),
        .o_quot (w_qy)
    );

    dgb_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(BIN_TOTAL)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_addr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_out_free  = !r_out_valid || i_ready;
        w_sweep_end = (32'(r_addr) == BIN_TOTAL - 1);
        w_in_range  = !w_qx[NUM_W-1] && !w_qy[NUM_W-1] &&
                      ($unsigned(w_qx) < NUM_W'(i_grid.bins_x)) &&
                      ($unsigned(w_qy) < NUM_W'(i_grid.bins_y));
        w_bin_addr  = ADDR_W'(w_qx[BXI_W-1:0]) * ADDR_W'(BINS_Y) +
                      ADDR_W'(w_qy[BYI_W-1:0]);
        w_cell_addr = ADDR_W'({r_cmd.col, r_idx[2]}) * ADDR_W'(BINS_Y) +
                      ADDR_W'({r_cmd.row, r_idx[1:0]});
        w_bit       = 3'(r_idx - 4'd1);
        if (!r_all) begin
            w_cls = CLS_NONE;
        end else if (r_sum > THR_MAGENTA) begin
            w_cls = CLS_MAGENTA;
        end else if (r_sum > THR_RED) begin
            w_cls = CLS_RED;
        end else if (r_sum > THR_YELLOW) begin
            w_cls = CLS_YELLOW;
        end else if (r_sum > THR_GREEN) begin
            w_cls = CLS_GREEN;
        end else if (r_sum > THR_CYAN) begin
            w_cls = CLS_CYAN;
        end else if (r_sum > THR_WHITE) begin
            w_cls = CLS_WHITE;
        end else begin
            w_cls = CLS_NONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (w_sweep_end) n_state = r_reply ? ST_EMIT : ST_IDLE;
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_ADD:   n_state = i_q_cmd.span_ok ? ST_DIV : ST_EMIT;
                        OP_READ:  n_state = i_q_cmd.cell_ok ? ST_CELL : ST_EMIT;
                        OP_CLEAR: n_state = ST_SWEEP;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_done_x) n_state = w_in_range ? ST_ADD_RD : ST_EMIT;
            end
            ST_ADD_RD:   n_state = ST_ADD_WR;
            ST_ADD_WR:   n_state = ST_EMIT;
            ST_CELL: begin
                if (r_idx == 4'd8) n_state = ST_CELL_FIN;
            end
            ST_CELL_FIN: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
        w_div_start = o_q_pop && (i_q_cmd.op == OP_ADD) && i_q_cmd.span_ok;
        w_raddr     = (r_state == ST_CELL) ? w_cell_addr : r_addr;
        w_we        = (r_state == ST_SWEEP) || (r_state == ST_ADD_WR);
        if (r_state == ST_SWEEP) begin
            w_wdata = '0;
        end else begin
            w_wdata = (&w_rdata) ? w_rdata : w_rdata + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_addr      <= '0;
            r_reply     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_SWEEP: begin
                    r_addr <= w_sweep_end ? '0 : r_addr + ADDR_W'(1);
                    if (w_sweep_end) r_reply <= 1'b0;
                end
                ST_IDLE: begin
                    r_idx <= '0;
                    if (i_q_valid && (i_q_cmd.op == OP_CLEAR)) begin
                        r_addr  <= '0;
                        r_reply <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (w_done_x) r_addr <= w_bin_addr;
                end
                ST_CELL: begin
                    r_idx <= r_idx + 4'd1;
                end
                default: begin
                end
            endcase

            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd <= i_q_cmd;
                r_res <= '0;
                r_sum <= '0;
                r_pat <= '0;
                r_all <= 1'b1;
            end
            ST_ADD_WR: r_res.counted <= 1'b1;
            ST_CELL: begin
                if (r_idx != 4'd0) begin
                    r_pat[w_bit] <= (w_rdata != '0);
                    if (w_rdata == '0) r_all <= 1'b0;
                    r_sum <= r_sum + SUM_W'(w_rdata);
                end
            end
            ST_CELL_FIN: begin
                r_res.dots <= r_pat;
                r_res.cls  <= w_cls;
            end
            default: begin
            end
        endcase
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_init  = (r_state == ST_SWEEP) && !r_reply;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !o_q_pop)
        else $error("command taken during clearing pass");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x == w_done_y)
        else $error("dividers finished on different cycles");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD_WR) |-> ($past(r_state) == ST_ADD_RD))
        else $error("bin update without preceding read");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result loaded outside emit state");
endmodule
